@@ hw/rtl/go_back_n_link_controller_unit_defines.svh @@
// Assertion helpers for the RTL of the link controller, used by gbn_ctrl.
// Both sample on the rising edge of clk and are masked while rst is high.
`ifndef GO_BACK_N_LINK_CONTROLLER_UNIT_DEFINES_SVH
`define GO_BACK_N_LINK_CONTROLLER_UNIT_DEFINES_SVH

// Property that must hold at every sampled edge out of reset
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition at one edge implies an expression at the following edge
`define GBN_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

@@ hw/rtl/gbn_pkg.sv @@
package gbn_pkg;

  // Window and payload sizing
  localparam int WINDOW       = 4;
  localparam int PAYLOAD_BITS = 32;
  localparam int SEQ_W        = 2;
  localparam int SEQ_SPACE    = 1 << SEQ_W;
  localparam int CAPACITY     = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE;
  localparam int IDX_W        = SEQ_W;
  localparam int CNT_W        = IDX_W + 1;
  localparam int PAYLOAD_W    = 32;
  localparam int AGE_W        = 32;
  localparam int KEEP_BITS    = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK =
    (KEEP_BITS >= PAYLOAD_W) ? {PAYLOAD_W{1'b1}} :
    PAYLOAD_W'((64'd1 << KEEP_BITS) - 64'd1);

  localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_ZERO     = '0;
  localparam logic [SEQ_W-1:0] SEQ_ONE      = SEQ_W'(1);
  localparam logic [SEQ_W-1:0] RX_SEQ_RESET = SEQ_W'(3);
  localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(10000000);

  // Stream packing
  localparam int TDATA_W   = 40;
  localparam int TDATA_PAD = TDATA_W - SEQ_W - PAYLOAD_W;
  localparam int S_TUSER_W = 3;
  localparam int M_TUSER_W = 5;

  typedef enum logic [1:0] {
    MODE_LINK  = 2'd0,
    MODE_SEND  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_TX_DATA = 2'd0,
    ACT_TX_ACK  = 2'd1,
    ACT_DELIVER = 2'd2,
    ACT_STATUS  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_WIN_FULL     = 3'd1,
    STS_ACK_RANGE    = 3'd2,
    STS_OUT_OF_ORDER = 3'd3,
    STS_TIMEOUT      = 3'd4
  } status_t;

  // One accepted input transaction
  typedef struct packed {
    mode_t                mode;
    logic                 is_ack;
    logic [SEQ_W-1:0]     seq;
    logic [PAYLOAD_W-1:0] payload;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    status_t              status;
    action_t              action;
    logic [SEQ_W-1:0]     seq;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last;
  } result_t;

  // Window store access from the sequencer
  typedef struct packed {
    logic                 pay_we;
    logic                 age_clear;
    logic                 age_step;
    logic [IDX_W-1:0]     idx;
    logic [PAYLOAD_W-1:0] wdata;
  } win_cmd_t;

  function automatic result_t make_result(action_t act, logic [SEQ_W-1:0] seq,
                                          logic [PAYLOAD_W-1:0] pay, status_t sts,
                                          logic last);
    result_t r;
    r.action  = act;
    r.seq     = seq;
    r.payload = pay;
    r.status  = sts;
    r.last    = last;
    return r;
  endfunction

endpackage

@@ hw/rtl/gbn_window.sv @@
module gbn_window (
  input  logic                                clk,
  input  gbn_pkg::win_cmd_t                   cmd,
  input  logic [gbn_pkg::AGE_W-1:0]           limit,
  output logic [gbn_pkg::PAYLOAD_W-1:0]       rd_payload,
  output logic                                age_expired
);

  // Entries are kept by sequence number, so an ack only moves the oldest pointer
  logic [gbn_pkg::PAYLOAD_W-1:0] pay_mem [gbn_pkg::SEQ_SPACE];
  logic [gbn_pkg::AGE_W-1:0]     age_mem [gbn_pkg::SEQ_SPACE];

  logic [gbn_pkg::AGE_W-1:0] age_cur;
  logic [gbn_pkg::AGE_W-1:0] age_inc;

  // Shared ageing unit: saturating increment and compare against the limit
  always_comb begin
    age_cur     = age_mem[cmd.idx];
    age_inc     = (age_cur == {gbn_pkg::AGE_W{1'b1}}) ? age_cur : age_cur + 1'b1;
    age_expired = age_inc > limit;
    rd_payload  = pay_mem[cmd.idx];
  end

  // Store updates
  always_ff @(posedge clk) begin
    if (cmd.pay_we) begin
      pay_mem[cmd.idx] <= cmd.wdata;
    end
    if (cmd.age_clear) begin
      age_mem[cmd.idx] <= '0;
    end else if (cmd.age_step) begin
      age_mem[cmd.idx] <= age_inc;
    end
  end

endmodule

@@ hw/rtl/gbn_out_fifo.sv @@
module gbn_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gbn_pkg::result_t   push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output gbn_pkg::result_t   out_data
);

  // Two-entry result queue decoupling the sequencer from the output stream
  gbn_pkg::result_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             pop;

  assign full      = fill[1];
  assign out_valid = fill != 2'd0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid & out_ready;

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ hw/rtl/gbn_ctrl.sv @@
`include "go_back_n_link_controller_unit_defines.svh"

module gbn_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gbn_pkg::in_item_t              in_item,
  output gbn_pkg::win_cmd_t              win_cmd,
  input  logic [gbn_pkg::PAYLOAD_W-1:0]  win_payload,
  input  logic                           age_expired,
  output logic                           out_push,
  output gbn_pkg::result_t               out_result,
  input  logic                           out_full
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_ACK    = 6'b000100,
    S_AGE    = 6'b001000,
    S_CHECK  = 6'b010000,
    S_RESEND = 6'b100000
  } state_t;

  state_t                         state, state_next;
  gbn_pkg::in_item_t              item;
  logic [gbn_pkg::SEQ_W-1:0]      oldest, oldest_next;
  logic [gbn_pkg::SEQ_W-1:0]      next_seq, next_seq_next;
  logic [gbn_pkg::CNT_W-1:0]      count, count_next;
  logic [gbn_pkg::SEQ_W-1:0]      last_rx, last_rx_next;
  logic [gbn_pkg::IDX_W-1:0]      idx, idx_next;
  logic                           expired, expired_next;

  logic [gbn_pkg::SEQ_W-1:0]      win_pos;
  logic                           at_last;
  logic [gbn_pkg::SEQ_W-1:0]      ack_dist;
  logic [gbn_pkg::CNT_W-1:0]      ack_n;
  logic                           ack_over;
  logic                           accept;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid & in_ready;

  // Window walk position and end-of-window test
  assign win_pos  = oldest + idx;
  assign at_last  = ({1'b0, idx} + gbn_pkg::CNT_ONE) == count;

  // Cumulative ack: frames retired, clipped to the outstanding count
  always_comb begin
    ack_dist = item.seq - oldest;
    ack_n    = {1'b0, ack_dist} + gbn_pkg::CNT_ONE;
    ack_over = ack_n > count;
    if (ack_over) begin
      ack_n = count;
    end
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    oldest_next   = oldest;
    next_seq_next = next_seq;
    count_next    = count;
    last_rx_next  = last_rx;
    idx_next      = idx;
    expired_next  = expired;
    out_push      = 1'b0;
    out_result    = gbn_pkg::make_result(gbn_pkg::ACT_STATUS, '0, '0, gbn_pkg::STS_OK,
                                         1'b1);
    win_cmd.pay_we    = 1'b0;
    win_cmd.age_clear = 1'b0;
    win_cmd.age_step  = 1'b0;
    win_cmd.idx       = win_pos;
    win_cmd.wdata     = item.payload;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (item.mode)
          gbn_pkg::MODE_LINK: begin
            if (!out_full) begin
              if (item.is_ack) begin
                out_push    = 1'b1;
                out_result  = gbn_pkg::make_result(gbn_pkg::ACT_STATUS, '0, '0,
                                ack_over ? gbn_pkg::STS_ACK_RANGE : gbn_pkg::STS_OK, 1'b1);
                oldest_next = oldest + ack_n[gbn_pkg::SEQ_W-1:0];
                count_next  = count - ack_n;
                state_next  = S_IDLE;
              end else if (item.seq == last_rx + gbn_pkg::SEQ_ONE) begin
                out_push     = 1'b1;
                out_result   = gbn_pkg::make_result(gbn_pkg::ACT_DELIVER, item.seq,
                                 item.payload, gbn_pkg::STS_OK, 1'b0);
                last_rx_next = item.seq;
                state_next   = S_ACK;
              end else begin
                out_push   = 1'b1;
                out_result = gbn_pkg::make_result(gbn_pkg::ACT_STATUS, '0, '0,
                               gbn_pkg::STS_OUT_OF_ORDER, 1'b1);
                state_next = S_IDLE;
              end
            end
          end

          gbn_pkg::MODE_SEND: begin
            if (!out_full) begin
              out_push   = 1'b1;
              state_next = S_IDLE;
              if (count >= gbn_pkg::CAPACITY_CNT) begin
                out_result = gbn_pkg::make_result(gbn_pkg::ACT_STATUS, '0, '0,
                               gbn_pkg::STS_WIN_FULL, 1'b1);
              end else begin
                win_cmd.pay_we    = 1'b1;
                win_cmd.age_clear = 1'b1;
                win_cmd.idx       = next_seq;
                out_result        = gbn_pkg::make_result(gbn_pkg::ACT_TX_DATA, next_seq,
                                      item.payload, gbn_pkg::STS_OK, 1'b1);
                count_next        = count + gbn_pkg::CNT_ONE;
                next_seq_next     = next_seq + gbn_pkg::SEQ_ONE;
              end
            end
          end

          gbn_pkg::MODE_TICK: begin
            if (count == gbn_pkg::CNT_ZERO) begin
              if (!out_full) begin
                out_push   = 1'b1;
                state_next = S_IDLE;
              end
            end else begin
              idx_next     = '0;
              expired_next = 1'b0;
              state_next   = S_AGE;
            end
          end

          gbn_pkg::MODE_SPARE: begin
            if (!out_full) begin
              out_push   = 1'b1;
              state_next = S_IDLE;
            end
          end

          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      // Acknowledge an in-order data frame after its delivery
      S_ACK: begin
        if (!out_full) begin
          out_push   = 1'b1;
          out_result = gbn_pkg::make_result(gbn_pkg::ACT_TX_ACK, item.seq, '0,
                         gbn_pkg::STS_OK, 1'b1);
          state_next = S_IDLE;
        end
      end

      // Age one outstanding frame per cycle through the shared unit
      S_AGE: begin
        win_cmd.age_step = 1'b1;
        expired_next     = expired | age_expired;
        if (at_last) begin
          idx_next   = '0;
          state_next = S_CHECK;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      S_CHECK: begin
        if (expired) begin
          state_next = S_RESEND;
        end else if (!out_full) begin
          out_push   = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Go back: resend the window oldest first, restarting each timer
      S_RESEND: begin
        if (!out_full) begin
          out_push          = 1'b1;
          win_cmd.age_clear = 1'b1;
          out_result        = gbn_pkg::make_result(gbn_pkg::ACT_TX_DATA, win_pos,
                                win_payload, gbn_pkg::STS_TIMEOUT, at_last);
          if (at_last) begin
            idx_next   = '0;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Latched input transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      item.mode    <= in_item.mode;
      item.is_ack  <= in_item.is_ack;
      item.seq     <= in_item.seq;
      item.payload <= in_item.payload & gbn_pkg::PAYLOAD_MASK;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      oldest   <= '0;
      next_seq <= '0;
      count    <= '0;
      last_rx  <= gbn_pkg::RX_SEQ_RESET;
      idx      <= '0;
      expired  <= 1'b0;
    end else begin
      state    <= state_next;
      oldest   <= oldest_next;
      next_seq <= next_seq_next;
      count    <= count_next;
      last_rx  <= last_rx_next;
      idx      <= idx_next;
      expired  <= expired_next;
    end
  end

  // Checks
  `GBN_ASSERT(a_count_cap, count <= gbn_pkg::CAPACITY_CNT, "outstanding count above capacity")
  `GBN_ASSERT(a_seq_track, next_seq == oldest + count[gbn_pkg::SEQ_W-1:0], "send seq drift")
  `GBN_ASSERT(a_no_overrun, out_push |-> !out_full, "result pushed into full queue")
  `GBN_ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE, "accepted transaction not taken up")

endmodule

@@ hw/rtl/go_back_n_link_controller_unit.sv @@
// Go-Back-N link controller, window of four, sequence numbers modulo four.
// Results are pushed into a two-entry output queue that drives m_tvalid from its
// registered fill level. s_tready is high only in the idle state, so each transaction
// is finished before the next is taken; a tick with frames outstanding ages them through
// one shared ageing unit, one entry per cycle, and on timeout resends each of them.
// Reset: synchronous rst empties the window and reloads timeout_limit with 10000000.
module go_back_n_link_controller_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [gbn_pkg::TDATA_W-1:0]        s_tdata,  // frame_seq[1:0], payload[33:2], zero pad
  input  logic [gbn_pkg::S_TUSER_W-1:0]      s_tuser,  // mode[1:0], frame_is_ack[2]
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [gbn_pkg::TDATA_W-1:0]        m_tdata,  // out_seq[1:0], out_payload[33:2], zero pad
  output logic [gbn_pkg::M_TUSER_W-1:0]      m_tuser,  // action[1:0], status[4:2]
  output logic                               m_tlast,
  // timeout_limit register write
  input  logic                               cfg_we,
  input  logic [gbn_pkg::AGE_W-1:0]          cfg_wdata
);

  logic [gbn_pkg::AGE_W-1:0]     timeout_limit;
  gbn_pkg::in_item_t             in_item;
  gbn_pkg::win_cmd_t             win_cmd;
  logic [gbn_pkg::PAYLOAD_W-1:0] win_payload;
  logic                          age_expired;
  logic                          res_push;
  gbn_pkg::result_t              res_in;
  gbn_pkg::result_t              res_out;
  logic                          res_full;

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= gbn_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_limit <= cfg_wdata;
    end
  end

  // Input unpacking
  always_comb begin
    in_item.mode    = gbn_pkg::mode_t'(s_tuser[1:0]);
    in_item.is_ack  = s_tuser[2];
    in_item.seq     = s_tdata[gbn_pkg::SEQ_W-1:0];
    in_item.payload = s_tdata[gbn_pkg::SEQ_W +: gbn_pkg::PAYLOAD_W];
  end

  gbn_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (in_item),
    .win_cmd     (win_cmd),
    .win_payload (win_payload),
    .age_expired (age_expired),
    .out_push    (res_push),
    .out_result  (res_in),
    .out_full    (res_full)
  );

  gbn_window u_window (
    .clk         (clk),
    .cmd         (win_cmd),
    .limit       (timeout_limit),
    .rd_payload  (win_payload),
    .age_expired (age_expired)
  );

  gbn_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_out)
  );

  // Output packing
  assign m_tdata = {{gbn_pkg::TDATA_PAD{1'b0}}, res_out.payload, res_out.seq};
  assign m_tuser = {res_out.status, res_out.action};
  assign m_tlast = res_out.last;

endmodule
